// File: rtl/hvt_pkg.sv
// Shared types and constants for the homogeneous vertex transform.
// Depends on nothing; every rtl file imports it.
package hvt_pkg;

  // Significand width handed to the rounding stage, signed exponent width
  localparam int SIG_W = 50;
  localparam int EXP_W = 12;

  // Unit latencies in cycles
  localparam int MUL_LAT = 3;
  localparam int ADD_LAT = 4;
  localparam int RCP_LAT = 9;

  // Matrix layout
  localparam int NUM_PAIRS = 8;
  localparam int NUM_ELEM  = 16;

  // Operation codes
  localparam logic [1:0] FN_VEC4  = 2'd0;
  localparam logic [1:0] FN_POINT = 2'd1;
  localparam logic [1:0] FN_DIR   = 2'd2;

  // binary32 constants
  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FP_INF  = 32'h7F80_0000;
  localparam logic [31:0] W_EPS   = 32'h3586_37BD;

  // Identity matrix after reset
  localparam logic [63:0] MAT_RST [NUM_PAIRS] = '{
    64'h0000_0000_3F80_0000, 64'h0,
    64'h3F80_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_3F80_0000,
    64'h0,                   64'h3F80_0000_0000_0000
  };

  // Unrounded operand for the shared rounding stage.
  // A one in sig[SIG_W-1] weighs 2^(expo-127).
  typedef struct packed {
    logic                    sign;
    logic [EXP_W-1:0]        expo;
    logic [SIG_W-1:0]        sig;
    logic                    special;
    logic [31:0]             spec_val;
  } rnd_in_t;

  // Sideband that travels with each item
  typedef struct packed {
    logic       vld;
    logic [1:0] func;
  } ctl_t;

  // Post-sum values that wait for the reciprocal
  typedef struct packed {
    logic        div;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } post_t;

  function automatic logic fp_is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] fp_canon(input logic [31:0] f);
    return fp_is_nan(f) ? FP_QNAN : f;
  endfunction

endpackage

// File: rtl/hvt_round.sv
// Two-stage normalize and round-to-nearest-even for binary32 results.
// Depends on hvt_pkg (rnd_in_t, constants).
module hvt_round import hvt_pkg::*; (
  input  logic        clk,
  input  rnd_in_t     rin,
  output logic [31:0] res
);

  rnd_in_t     s1_r;
  logic [5:0]  lz_r, lz_nxt;
  logic [31:0] res_r, res_nxt;

  // Count leading zeros of the significand
  always_comb begin
    lz_nxt = 6'(SIG_W);
    for (int i = 0; i < SIG_W; i++) begin
      if (rin.sig[i]) lz_nxt = 6'(SIG_W - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= rin;
    lz_r <= lz_nxt;
  end

  // Shift into place, round, pack
  always_comb begin
    logic signed [EXP_W-1:0] ex;
    logic signed [EXP_W-1:0] e2;
    logic signed [EXP_W-1:0] nr;
    logic [5:0]              lsh;
    logic [5:0]              rsh;
    logic [8:0]              field;
    logic [8:0]              base;
    logic [2*SIG_W-1:0]      shr;
    logic [23:0]             mant;
    logic                    guard;
    logic                    sticky;
    logic                    inc;
    logic [32:0]             packed_v;
    ex    = $signed(s1_r.expo);
    e2    = ex - $signed({{(EXP_W-6){1'b0}}, lz_r});
    nr    = $signed(EXP_W'(1)) - ex;
    lsh   = '0;
    rsh   = '0;
    field = '0;
    if (e2 > $signed(EXP_W'(0))) begin
      lsh   = lz_r;
      field = e2[8:0];
    end else if (ex > $signed(EXP_W'(0))) begin
      lsh = 6'(ex - $signed(EXP_W'(1)));
    end else if (nr > $signed(EXP_W'(SIG_W))) begin
      rsh = 6'(SIG_W);
    end else begin
      rsh = nr[5:0];
    end
    shr      = {s1_r.sig << lsh, {SIG_W{1'b0}}} >> rsh;
    mant     = shr[2*SIG_W-1 -: 24];
    guard    = shr[2*SIG_W-25];
    sticky   = |shr[2*SIG_W-26:0];
    inc      = guard & (sticky | mant[0]);
    base     = (field != 9'd0) ? field - 9'd1 : 9'd0;
    packed_v = {1'b0, base, 23'd0} + {9'd0, mant} + {32'd0, inc};
    if (s1_r.special) begin
      res_nxt = s1_r.spec_val;
    end else if (s1_r.sig == '0) begin
      res_nxt = {s1_r.sign, 31'd0};
    end else if (packed_v >= {1'b0, FP_INF}) begin
      res_nxt = {s1_r.sign, FP_INF[30:0]};
    end else begin
      res_nxt = {s1_r.sign, packed_v[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// File: rtl/hvt_fmul.sv
// Pipelined binary32 multiplier: unpack and 24x24 product, then rounding.
// Depends on hvt_pkg and hvt_round.
module hvt_fmul import hvt_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic                sign_r, sign_nxt;
  logic [EXP_W-1:0]    expo_r, expo_nxt;
  logic                spec_r, spec_nxt;
  logic [31:0]         sval_r, sval_nxt;
  logic [47:0]         prod_r, prod_nxt;
  rnd_in_t             rin;

  // Unpack, flag special operands, multiply significands
  always_comb begin
    logic [7:0]  eae;
    logic [7:0]  ebe;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    eae      = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    ebe      = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma       = {a[30:23] != 8'd0, a[22:0]};
    mb       = {b[30:23] != 8'd0, b[22:0]};
    a_inf    = (a[30:0] == FP_INF[30:0]);
    b_inf    = (b[30:0] == FP_INF[30:0]);
    a_zero   = (ma == 24'd0);
    b_zero   = (mb == 24'd0);
    sign_nxt = a[31] ^ b[31];
    expo_nxt = EXP_W'($signed({4'd0, eae}) + $signed({4'd0, ebe}) - $signed(EXP_W'(126)));
    prod_nxt = ma * mb;
    spec_nxt = 1'b1;
    if (fp_is_nan(a) || fp_is_nan(b) || (a_inf && b_zero) || (b_inf && a_zero)) begin
      sval_nxt = FP_QNAN;
    end else if (a_inf || b_inf) begin
      sval_nxt = {sign_nxt, FP_INF[30:0]};
    end else if (a_zero || b_zero) begin
      sval_nxt = {sign_nxt, 31'd0};
    end else begin
      spec_nxt = 1'b0;
      sval_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    sign_r <= sign_nxt;
    expo_r <= expo_nxt;
    spec_r <= spec_nxt;
    sval_r <= sval_nxt;
    prod_r <= prod_nxt;
  end

  assign rin = '{sign: sign_r, expo: expo_r, sig: {prod_r, 2'b00},
                 special: spec_r, spec_val: sval_r};

  hvt_round u_rnd (
    .clk (clk),
    .rin (rin),
    .res (p)
  );

endmodule

// File: rtl/hvt_fadd.sv
// Pipelined binary32 adder: order and align, add or subtract, then rounding.
// Depends on hvt_pkg and hvt_round.
module hvt_fadd import hvt_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);

  logic [23:0] bm_r, bm_nxt;
  logic [23:0] sm_r, sm_nxt;
  logic [7:0]  be_r, be_nxt;
  logic [7:0]  d_r, d_nxt;
  logic        bs_r, bs_nxt;
  logic        sub_r, sub_nxt;
  logic        zs_r, zs_nxt;
  logic        spec_r, spec_nxt;
  logic [31:0] sval_r, sval_nxt;
  rnd_in_t     rin_r, rin_nxt;

  // Order operands by magnitude, flag specials
  always_comb begin
    logic [7:0]  eae;
    logic [7:0]  ebe;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        a_inf;
    logic        b_inf;
    logic        a_big;
    eae     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    ebe     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma      = {a[30:23] != 8'd0, a[22:0]};
    mb      = {b[30:23] != 8'd0, b[22:0]};
    a_inf   = (a[30:0] == FP_INF[30:0]);
    b_inf   = (b[30:0] == FP_INF[30:0]);
    a_big   = (a[30:0] >= b[30:0]);
    bm_nxt  = a_big ? ma : mb;
    sm_nxt  = a_big ? mb : ma;
    be_nxt  = a_big ? eae : ebe;
    d_nxt   = a_big ? eae - ebe : ebe - eae;
    bs_nxt  = a_big ? a[31] : b[31];
    sub_nxt = a[31] ^ b[31];
    zs_nxt  = a[31] & b[31];
    spec_nxt = 1'b1;
    if (fp_is_nan(a) || fp_is_nan(b) || (a_inf && b_inf && sub_nxt)) begin
      sval_nxt = FP_QNAN;
    end else if (a_inf) begin
      sval_nxt = {a[31], FP_INF[30:0]};
    end else if (b_inf) begin
      sval_nxt = {b[31], FP_INF[30:0]};
    end else begin
      spec_nxt = 1'b0;
      sval_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    bm_r   <= bm_nxt;
    sm_r   <= sm_nxt;
    be_r   <= be_nxt;
    d_r    <= d_nxt;
    bs_r   <= bs_nxt;
    sub_r  <= sub_nxt;
    zs_r   <= zs_nxt;
    spec_r <= spec_nxt;
    sval_r <= sval_nxt;
  end

  // Align the smaller operand with sticky, then add or subtract
  always_comb begin
    logic [4:0]       dd;
    logic [SIG_W-1:0] big_ext;
    logic [SIG_W-1:0] sm_ext;
    logic [SIG_W-1:0] mask;
    logic [SIG_W-1:0] aligned;
    logic [SIG_W-1:0] sum;
    dd      = (d_r > 8'd31) ? 5'd31 : d_r[4:0];
    big_ext = {1'b0, bm_r, 25'd0};
    sm_ext  = {1'b0, sm_r, 25'd0};
    mask    = ~({SIG_W{1'b1}} << dd);
    aligned = (sm_ext >> dd) | {{(SIG_W-1){1'b0}}, |(sm_ext & mask)};
    sum     = sub_r ? big_ext - aligned : big_ext + aligned;
    rin_nxt = '{sign: (sum == '0) ? zs_r : bs_r,
                expo: EXP_W'({1'b0, be_r} + 9'd1),
                sig: sum, special: spec_r, spec_val: sval_r};
  end

  always_ff @(posedge clk) begin
    rin_r <= rin_nxt;
  end

  hvt_round u_rnd (
    .clk (clk),
    .rin (rin_r),
    .res (s)
  );

endmodule

// File: rtl/hvt_frcp.sv
// Pipelined binary32 reciprocal: radix-2 restoring division, four quotient
// bits per stage over seven stages, then rounding. Depends on hvt_pkg, hvt_round.
module hvt_frcp import hvt_pkg::*; (
  input  logic        clk,
  input  logic [31:0] w,
  output logic [31:0] r
);

  localparam int NST = 7;
  localparam int BPS = 4;
  localparam int QW  = NST * BPS;

  typedef struct packed {
    logic [24:0]      rem;
    logic [QW-1:0]    quo;
    logic [23:0]      m;
    logic             sign;
    logic [EXP_W-1:0] expo;
    logic             special;
    logic [31:0]      spec_val;
  } dv_t;

  dv_t     dv_in;
  dv_t     dv_r   [NST];
  dv_t     dv_nxt [NST];
  rnd_in_t rin;

  // Unpack the divisor and flag specials
  always_comb begin
    dv_in.rem      = 25'(1) << 23;
    dv_in.quo      = '0;
    dv_in.m        = {1'b1, w[22:0]};
    dv_in.sign     = w[31];
    dv_in.expo     = EXP_W'(9'd254 - {1'b0, w[30:23]});
    dv_in.special  = 1'b1;
    if (fp_is_nan(w)) begin
      dv_in.spec_val = FP_QNAN;
    end else if (w[30:0] == FP_INF[30:0]) begin
      dv_in.spec_val = {w[31], 31'd0};
    end else if (w[30:23] == 8'd0) begin
      dv_in.spec_val = {w[31], FP_INF[30:0]};
    end else begin
      dv_in.special  = 1'b0;
      dv_in.spec_val = '0;
    end
  end

  // Each stage retires four quotient bits
  for (genvar st = 0; st < NST; st++) begin : g_st
    always_comb begin
      dv_t src;
      src = (st == 0) ? dv_in : dv_r[(st == 0) ? 0 : st - 1];
      dv_nxt[st] = src;
      for (int k = 0; k < BPS; k++) begin
        if (dv_nxt[st].rem >= {1'b0, dv_nxt[st].m}) begin
          dv_nxt[st].rem = dv_nxt[st].rem - {1'b0, dv_nxt[st].m};
          dv_nxt[st].quo = {dv_nxt[st].quo[QW-2:0], 1'b1};
        end else begin
          dv_nxt[st].quo = {dv_nxt[st].quo[QW-2:0], 1'b0};
        end
        dv_nxt[st].rem = {dv_nxt[st].rem[23:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      dv_r[st] <= dv_nxt[st];
    end
  end

  assign rin = '{sign: dv_r[NST-1].sign, expo: dv_r[NST-1].expo,
                 sig: {dv_r[NST-1].quo, {(SIG_W-QW-1){1'b0}}, dv_r[NST-1].rem != 25'd0},
                 special: dv_r[NST-1].special, spec_val: dv_r[NST-1].spec_val};

  hvt_round u_rnd (
    .clk (clk),
    .rin (rin),
    .res (r)
  );

endmodule

// File: rtl/homogeneous_vertex_transform.sv
// Homogeneous vertex transform: 4x4 binary32 matrix times vector, optional divide.
// Throughput: one vertex per cycle; busy stays low, the adder chain and the
// reciprocal pipeline are fully staged. Synchronous reset loads the identity
// matrix and clears the valid bits. Depends on hvt_pkg, hvt_fmul, hvt_fadd, hvt_frcp.
module homogeneous_vertex_transform import hvt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  input  logic [31:0] in_w,
  output logic        out_valid,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_w,
  output logic        out_divided,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int DIV_T = MUL_LAT + 3 * ADD_LAT;
  localparam int PST_D = RCP_LAT + MUL_LAT;
  localparam int CTL_D = DIV_T + PST_D + 1;

  logic [63:0] mat_r [NUM_PAIRS];
  logic [31:0] el    [NUM_ELEM];
  logic [31:0] vec_r [4];
  ctl_t        ctl_r [CTL_D];
  logic [31:0] prd   [4][4];
  logic [31:0] p2_d  [4][ADD_LAT];
  logic [31:0] p3_d  [4][2*ADD_LAT];
  logic [31:0] s1    [4];
  logic [31:0] s2    [4];
  logic [31:0] s3    [4];
  logic [31:0] s2_d  [4][ADD_LAT];
  post_t       pst_nxt;
  post_t       pst_d [PST_D];
  logic [31:0] inv;
  logic [31:0] q     [3];
  logic        accept;
  logic        out_valid_r;
  logic [31:0] out_x_r, out_y_r, out_z_r, out_w_r;
  logic [31:0] out_x_nxt, out_y_nxt, out_z_nxt, out_w_nxt;
  logic        out_div_r, out_div_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Matrix registers; writes beyond the last pair drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PAIRS; k++) mat_r[k] <= MAT_RST[k];
    end else if (cfg_we && (cfg_index < 4'(NUM_PAIRS))) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  for (genvar e = 0; e < NUM_ELEM; e++) begin : g_el
    assign el[e] = mat_r[e/2][(e%2)*32 +: 32];
  end

  // Capture the vertex; a point takes w as one
  always_ff @(posedge clk) begin
    vec_r[0] <= in_x;
    vec_r[1] <= in_y;
    vec_r[2] <= in_z;
    vec_r[3] <= (in_func == FN_POINT) ? FP_ONE : in_w;
  end

  // Advance the sideband with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CTL_D; k++) ctl_r[k] <= '0;
    end else begin
      ctl_r[0] <= '{vld: accept, func: in_func};
      for (int k = 1; k < CTL_D; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  // Products, then sums left to right per row
  for (genvar rw = 0; rw < 4; rw++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      hvt_fmul u_mul (.clk(clk), .a(el[rw*4+c]), .b(vec_r[c]), .p(prd[rw][c]));
    end

    always_ff @(posedge clk) begin
      p2_d[rw][0] <= prd[rw][2];
      s2_d[rw][0] <= s2[rw];
      for (int k = 1; k < ADD_LAT; k++) begin
        p2_d[rw][k] <= p2_d[rw][k-1];
        s2_d[rw][k] <= s2_d[rw][k-1];
      end
      p3_d[rw][0] <= prd[rw][3];
      for (int k = 1; k < 2*ADD_LAT; k++) p3_d[rw][k] <= p3_d[rw][k-1];
    end

    hvt_fadd u_add1 (.clk(clk), .a(prd[rw][0]), .b(prd[rw][1]), .s(s1[rw]));
    hvt_fadd u_add2 (.clk(clk), .a(s1[rw]), .b(p2_d[rw][ADD_LAT-1]), .s(s2[rw]));
    hvt_fadd u_add3 (.clk(clk), .a(s2[rw]), .b(p3_d[rw][2*ADD_LAT-1]), .s(s3[rw]));
  end

  // Pick the sums for the mode and decide on the divide
  always_comb begin
    logic dir;
    dir       = (ctl_r[DIV_T].func == FN_DIR);
    pst_nxt.x = dir ? s2_d[0][ADD_LAT-1] : s3[0];
    pst_nxt.y = dir ? s2_d[1][ADD_LAT-1] : s3[1];
    pst_nxt.z = dir ? s2_d[2][ADD_LAT-1] : s3[2];
    pst_nxt.w = s3[3];
    pst_nxt.div = (ctl_r[DIV_T].func == FN_POINT) && (s3[3][30:0] > W_EPS[30:0]) &&
                  (s3[3][30:0] <= FP_INF[30:0]);
  end

  // Hold the sums while the reciprocal and the scaling run
  always_ff @(posedge clk) begin
    pst_d[0] <= pst_nxt;
    for (int k = 1; k < PST_D; k++) pst_d[k] <= pst_d[k-1];
  end

  hvt_frcp u_rcp (.clk(clk), .w(pst_nxt.w), .r(inv));

  hvt_fmul u_qx (.clk(clk), .a(pst_d[RCP_LAT-1].x), .b(inv), .p(q[0]));
  hvt_fmul u_qy (.clk(clk), .a(pst_d[RCP_LAT-1].y), .b(inv), .p(q[1]));
  hvt_fmul u_qz (.clk(clk), .a(pst_d[RCP_LAT-1].z), .b(inv), .p(q[2]));

  // Select the result for the mode
  always_comb begin
    post_t pf;
    pf          = pst_d[PST_D-1];
    out_x_nxt   = '0;
    out_y_nxt   = '0;
    out_z_nxt   = '0;
    out_w_nxt   = '0;
    out_div_nxt = 1'b0;
    unique case (ctl_r[CTL_D-1].func)
      FN_VEC4: begin
        out_x_nxt = pf.x;
        out_y_nxt = pf.y;
        out_z_nxt = pf.z;
        out_w_nxt = pf.w;
      end
      FN_POINT: begin
        out_x_nxt   = pf.div ? q[0] : pf.x;
        out_y_nxt   = pf.div ? q[1] : pf.y;
        out_z_nxt   = pf.div ? q[2] : pf.z;
        out_w_nxt   = pf.w;
        out_div_nxt = pf.div;
      end
      FN_DIR: begin
        out_x_nxt = pf.x;
        out_y_nxt = pf.y;
        out_z_nxt = pf.z;
      end
      default: begin
        out_div_nxt = 1'b0;
      end
    endcase
  end

  // Output register; one strobe per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_r[CTL_D-1].vld;
    end
    out_x_r   <= fp_canon(out_x_nxt);
    out_y_r   <= fp_canon(out_y_nxt);
    out_z_r   <= fp_canon(out_z_nxt);
    out_w_r   <= fp_canon(out_w_nxt);
    out_div_r <= out_div_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_z       = out_z_r;
  assign out_w       = out_w_r;
  assign out_divided = out_div_r;

`ifndef SYNTH
  // A divided result always carries a w that is a number above the threshold
  a_div_w: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divided) |->
      ((out_w[30:0] > W_EPS[30:0]) && (out_w[30:0] <= FP_INF[30:0])))
    else $error("divided result with small or NaN w");

  // A direction transfer leaves w at zero and never divides
  a_dir_w: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r[CTL_D-1].vld && (ctl_r[CTL_D-1].func == FN_DIR)) |=>
      (out_valid && (out_w == 32'd0) && !out_divided))
    else $error("direction transfer with nonzero w or divide");

  // Only a point can be divided
  a_div_fn: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r[CTL_D-1].vld && (ctl_r[CTL_D-1].func != FN_POINT)) |=> !out_divided)
    else $error("divide flagged outside point mode");
`endif

endmodule
